@@ rtl/sstk_pkg.sv @@
package sstk_pkg;

  typedef enum logic [1:0] {
    OP_ADD      = 2'd0,
    OP_DISPATCH = 2'd1,
    OP_REPORT   = 2'd2,
    OP_NONE     = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_NO_SRV   = 2'd2,
    ST_BAD_IDX  = 2'd3
  } status_e;

  localparam logic [1:0] REG_ALPHA      = 2'd0;
  localparam logic [1:0] REG_REDUNDANCY = 2'd1;

  localparam logic [31:0] LAT_INIT   = 32'd100 << 16;
  localparam logic [16:0] ONE_Q16    = 17'h10000;
  localparam logic [31:0] FRESH_SECS = 32'd60;

  typedef struct packed {
    logic        start;
    logic [48:0] dividend;
    logic [32:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [48:0] quotient;
  } div_rsp_t;

endpackage

@@ rtl/server_score_top_k_selector.sv @@
// Channel   | Dir | Fields (low bit first)
// s_axis    | in  | tdata: opcode[1:0] server_index[5:2] measured_latency[21:6]
//           |     |        succeeded[22] now_seconds[54:23]
// m_axis    | out | tdata: chosen_index[3:0] status[5:4]; tlast: last_of_run
// apb       | cfg | 0x0 smoothing_alpha, 0x4 redundancy
// Dispatch scores each server with two serial divisions through one shared 49-step
// divider, then makes one selection pass over the servers per pick.
// The input is not ready while a word is in work or a result waits in the
// output register. Reset clears the server count and the sequencer and sets the registers to their defaults.
module server_score_top_k_selector
  import sstk_pkg::*;
#(
  parameter int unsigned MAX_SERVERS = 16,
  parameter int unsigned MAX_PICK    = 5
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,   // opcode, server_index, measured_latency,
                                      // succeeded, now_seconds
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // chosen_index, status
  output logic        m_axis_tlast,   // last_of_run
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned IW = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
  localparam int unsigned CW = $clog2(MAX_SERVERS + 1);
  localparam int unsigned PW = $clog2(MAX_PICK + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_DIV1, S_DIV1W, S_DIV2, S_DIV2W, S_KEY, S_SCAN, S_EMIT,
    S_BUMP, S_REP1, S_REP2, S_REP3, S_OUT
  } state_e;

  state_e state_q, state_d;

  logic [16:0] alpha_q;
  logic [2:0]  red_q;
  logic [CW-1:0] cnt_q;

  logic [31:0] lat_m  [MAX_SERVERS];
  logic [16:0] suc_m  [MAX_SERVERS];
  logic [15:0] act_m  [MAX_SERVERS];
  logic [31:0] qt_m   [MAX_SERVERS];
  logic [31:0] rt_m   [MAX_SERVERS];
  logic [31:0] ls_m   [MAX_SERVERS];
  logic [35:0] key_q  [MAX_SERVERS];
  logic [MAX_SERVERS-1:0] taken_q;

  logic [3:0]  sidx_q;
  logic [15:0] meas_q;
  logic        ok_q;
  logic [31:0] now_q;
  logic [IW-1:0] i_q;
  logic [PW-1:0] k_q, n_q;
  logic [17:0] lw_q;
  logic [IW-1:0] best_q;
  logic        have_q;
  logic [IW-1:0] pick_q [MAX_PICK];
  logic [63:0] acc_q;
  logic        ov_q;
  logic [3:0]  oidx_q;
  logic [1:0]  ost_q;
  logic        olast_q;

  div_req_t dreq;
  div_rsp_t drsp;

  sstk_divider u_div (.clk_i(clk_i), .rst_ni(rst_ni), .req_i(dreq), .rsp_o(drsp));

  logic cfg_we;
  assign cfg_we = psel && penable && pwrite;
  assign pready = 1'b1;
  always_comb begin
    unique case (paddr[2])
      1'b0:    prdata = {15'd0, alpha_q};
      default: prdata = {29'd0, red_q};
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q <= 17'd6554;
      red_q   <= 3'd3;
    end else if (cfg_we) begin
      if (paddr[2] == REG_ALPHA[0]) alpha_q <= pwdata[16:0];
      else if (paddr[2] == REG_REDUNDANCY[0]) red_q <= pwdata[2:0];
    end
  end

  logic        in_acc;
  assign s_axis_tready = (state_q == S_IDLE) && !ov_q;
  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = {2'd0, ost_q, oidx_q};
  assign m_axis_tlast  = olast_q;

  // shared multiply-add for smoothing
  logic [16:0] a_sat;
  logic [31:0] sm_x, sm_old;
  logic [63:0] sm_sum;
  assign a_sat  = (alpha_q > ONE_Q16) ? ONE_Q16 : alpha_q;
  assign sm_sum = 64'(a_sat) * 64'(sm_x) + 64'(ONE_Q16 - a_sat) * 64'(sm_old) + 64'd32768;

  logic [2:0]    nsel;
  logic [PW-1:0] n_calc;
  logic [31:0]   age;
  logic          fresh;
  logic [35:0]   raw;
  logic          better;
  logic [IW-1:0] sx;
  assign sx = IW'(sidx_q);
  assign nsel = (32'(red_q) > MAX_PICK) ? 3'(MAX_PICK) : red_q;
  always_comb begin
    n_calc = PW'(nsel);
    if (32'(nsel) > 32'(cnt_q)) n_calc = PW'(cnt_q);
  end
  assign age   = now_q - ls_m[i_q];
  assign fresh = (age < FRESH_SECS) || age[31];
  assign raw   = 36'(lw_q) * 36'd2 + 36'(suc_m[i_q]) * 36'd2 + 36'(drsp.quotient[17:0]);
  assign better = !taken_q[i_q] && (!have_q || key_q[i_q] > key_q[best_q]);

  logic out_fire;
  assign out_fire = ov_q && m_axis_tready;

  always_comb begin
    state_d = state_q;
    dreq    = '0;
    sm_x    = '0;
    sm_old  = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          unique case (op_e'(s_axis_tdata[1:0]))
            OP_ADD:      state_d = S_OUT;
            OP_DISPATCH: state_d = (n_calc == '0) ? S_OUT : S_DIV1;
            OP_REPORT:   state_d = S_REP1;
            default:     state_d = S_IDLE;
          endcase
        end
      end
      S_DIV1: begin
        dreq.start    = 1'b1;
        dreq.dividend = 49'd100 << 32;
        dreq.divisor  = 33'(32'd100 << 16) + 33'(lat_m[i_q]);
        state_d = S_DIV1W;
      end
      S_DIV1W: if (drsp.done) state_d = S_DIV2;
      S_DIV2: begin
        dreq.start    = 1'b1;
        dreq.dividend = 49'd10 << 16;
        dreq.divisor  = 33'd10 + 33'(act_m[i_q]);
        state_d = S_DIV2W;
      end
      S_DIV2W: if (drsp.done) state_d = S_KEY;
      S_KEY: state_d = (32'(i_q) + 1 >= 32'(cnt_q)) ? S_SCAN : S_DIV1;
      S_SCAN: if (32'(i_q) + 1 >= 32'(cnt_q)) state_d = S_EMIT;
      S_EMIT: if (!ov_q) state_d = (k_q + 1'b1 >= n_q) ? S_BUMP : S_SCAN;
      S_BUMP: if (32'(k_q) + 1 >= 32'(n_q)) state_d = S_IDLE;
      S_REP1: begin
        sm_x = {meas_q, 16'd0}; sm_old = lat_m[sx];
        state_d = S_REP2;
      end
      S_REP2: begin
        sm_x = ok_q ? 32'(ONE_Q16) : 32'd0; sm_old = 32'(suc_m[sx]);
        state_d = S_REP3;
      end
      S_REP3: state_d = S_OUT;
      S_OUT: if (!ov_q) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_fire) ov_q <= 1'b0;
      if (state_q == S_IDLE && in_acc && s_axis_tdata[1:0] == OP_ADD
          && 32'(cnt_q) < MAX_SERVERS) cnt_q <= cnt_q + 1'b1;
      if ((state_q == S_OUT || state_q == S_EMIT) && !ov_q) ov_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        sidx_q <= s_axis_tdata[5:2];
        meas_q <= s_axis_tdata[21:6];
        ok_q   <= s_axis_tdata[22];
        now_q  <= s_axis_tdata[54:23];
        i_q    <= '0;
        k_q    <= '0;
        have_q <= 1'b0;
        taken_q <= '0;
        n_q    <= n_calc;
        olast_q <= 1'b1;
        if (in_acc) begin
          unique case (op_e'(s_axis_tdata[1:0]))
            OP_ADD: begin
              if (32'(cnt_q) >= MAX_SERVERS) begin
                oidx_q <= '0; ost_q <= ST_FULL;
              end else begin
                oidx_q <= 4'(cnt_q); ost_q <= ST_OK;
                lat_m[cnt_q[IW-1:0]] <= LAT_INIT;
                suc_m[cnt_q[IW-1:0]] <= ONE_Q16;
                act_m[cnt_q[IW-1:0]] <= '0;
                qt_m[cnt_q[IW-1:0]]  <= '0;
                rt_m[cnt_q[IW-1:0]]  <= '0;
                ls_m[cnt_q[IW-1:0]]  <= s_axis_tdata[54:23];
              end
            end
            OP_DISPATCH: begin
              oidx_q <= '0; ost_q <= ST_NO_SRV;
            end
            default: begin
              oidx_q <= s_axis_tdata[5:2]; ost_q <= ST_OK;
            end
          endcase
        end
      end
      S_DIV1W: if (drsp.done) lw_q <= drsp.quotient[17:0];
      S_KEY: begin
        key_q[i_q] <= (qt_m[i_q] == 32'd0) ? 36'd0 : (fresh ? raw * 36'd6 : raw * 36'd5);
        i_q <= (32'(i_q) + 1 >= 32'(cnt_q)) ? '0 : i_q + 1'b1;
      end
      S_SCAN: begin
        if (better) begin
          best_q <= i_q; have_q <= 1'b1;
        end
        i_q <= (32'(i_q) + 1 >= 32'(cnt_q)) ? '0 : i_q + 1'b1;
      end
      S_EMIT: if (!ov_q) begin
        taken_q[best_q] <= 1'b1;
        pick_q[k_q[$clog2(MAX_PICK+1)-1:0] < PW'(MAX_PICK) ?
               k_q : '0] <= best_q;
        oidx_q  <= 4'(best_q);
        ost_q   <= ST_OK;
        olast_q <= (k_q + 1'b1 >= n_q);
        have_q  <= 1'b0;
        k_q     <= (k_q + 1'b1 >= n_q) ? '0 : k_q + 1'b1;
      end
      S_BUMP: begin
        if (act_m[pick_q[k_q]] != 16'hFFFF) act_m[pick_q[k_q]] <= act_m[pick_q[k_q]] + 16'd1;
        if (qt_m[pick_q[k_q]] != 32'hFFFFFFFF) qt_m[pick_q[k_q]] <= qt_m[pick_q[k_q]] + 32'd1;
        k_q <= k_q + 1'b1;
      end
      S_REP1: begin
        if (32'(sidx_q) >= 32'(cnt_q)) begin
          ost_q <= ST_BAD_IDX;
        end else if (rt_m[sx] == 32'd0) begin
          acc_q <= {16'd0, meas_q, 32'd0};
        end else begin
          acc_q <= sm_sum;
        end
      end
      S_REP2: begin
        if (32'(sidx_q) < 32'(cnt_q)) begin
          lat_m[sx] <= acc_q[47:16];
          suc_m[sx] <= sm_sum[32:16];
          if (rt_m[sx] != 32'hFFFFFFFF) rt_m[sx] <= rt_m[sx] + 32'd1;
          if (ok_q) ls_m[sx] <= now_q;
          if (act_m[sx] != 16'd0) act_m[sx] <= act_m[sx] - 16'd1;
        end
      end
      default: ;
    endcase
  end

endmodule

@@ rtl/sstk_divider.sv @@
module sstk_divider
  import sstk_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  localparam int unsigned NBits = 49;

  logic [48:0] quo_q, quo_d;
  logic [33:0] rem_q, rem_d;
  logic [32:0] dvs_q, dvs_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [33:0] trial;

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q[32:0], quo_q[48]};
    if (req_i.start) begin
      quo_d  = req_i.dividend;
      rem_d  = '0;
      dvs_d  = req_i.divisor;
      cnt_d  = 6'(NBits);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = trial - {1'b0, dvs_q};
        quo_d = {quo_q[47:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[47:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 100ps

module tb;
  import sstk_pkg::*;

  localparam int unsigned NSRV  = 16;
  localparam int unsigned NPICK = 5;
  localparam int unsigned SETTLE_CYCLES = 60;

  typedef struct {
    logic [3:0] idx;
    logic       last;
    status_e    status;
  } pick_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_valid = 1'b0;
  logic        s_ready;
  logic [55:0] s_data = '0;
  logic        m_valid;
  logic        m_ready = 1'b0;
  logic [7:0]  m_data;
  logic        m_last;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  server_score_top_k_selector uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid(s_valid), .s_axis_tready(s_ready), .s_axis_tdata(s_data),
    .m_axis_tvalid(m_valid), .m_axis_tready(m_ready), .m_axis_tdata(m_data),
    .m_axis_tlast(m_last),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  initial begin
    #20_000_000;
    $display("Verification failed");
    $finish;
  end

  // scoreboard state mirrored from the block
  logic [16:0] alpha_q = 17'd6554;
  logic [2:0]  redund_q = 3'd3;
  int unsigned srv_count = 0;
  logic [31:0] lat_avg [NSRV];
  logic [16:0] succ_avg [NSRV];
  logic [15:0] active_cnt [NSRV];
  logic [31:0] query_cnt [NSRV];
  logic [31:0] resp_cnt [NSRV];
  logic [31:0] last_ok_time [NSRV];

  pick_t       pending_picks [$];
  int          errors = 0;
  bit          idle_on = 1'b1;
  int          hold_left = 0;
  int          stall_left = 0;
  logic [31:0] clock_now = 32'd1000;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    errors++;
  endtask

  function automatic logic [31:0] smooth(input logic [31:0] old, input logic [31:0] x);
    logic [63:0] a;
    logic [63:0] sum;
    a = (alpha_q > 17'h10000) ? 64'h10000 : 64'(alpha_q);
    sum = a * 64'(x) + (64'h10000 - a) * 64'(old) + 64'd32768;
    return sum[47:16];
  endfunction

  function automatic logic [63:0] server_key(input int i, input logic [31:0] now);
    logic [63:0] lw;
    logic [63:0] lp;
    logic [63:0] raw;
    logic [31:0] age;
    if (query_cnt[i] == 0) return 64'd0;
    lw = (64'd100 << 32) / ((64'd100 << 16) + 64'(lat_avg[i]));
    lp = (64'd10 << 16) / (64'd10 + 64'(active_cnt[i]));
    raw = 2 * lw + 2 * 64'(succ_avg[i]) + lp;
    age = now - last_ok_time[i];
    return (age < 32'd60 || age[31]) ? raw * 6 : raw * 5;
  endfunction

  function automatic void push_pick(input int idx, input bit last, input status_e st);
    pick_t p;
    p.idx = idx[3:0];
    p.last = last;
    p.status = st;
    pending_picks.push_back(p);
  endfunction

  function automatic void predict_word(input op_e op, input logic [3:0] sidx,
                                       input logic [15:0] meas, input bit ok,
                                       input logic [31:0] now);
    logic [63:0] keys [NSRV];
    bit taken [NSRV];
    int chosen [NPICK];
    int n;
    int best;
    bit have;
    case (op)
      OP_ADD: begin
        if (srv_count >= NSRV) begin
          push_pick(0, 1'b1, ST_FULL);
        end else begin
          lat_avg[srv_count] = LAT_INIT;
          succ_avg[srv_count] = ONE_Q16;
          active_cnt[srv_count] = '0;
          query_cnt[srv_count] = '0;
          resp_cnt[srv_count] = '0;
          last_ok_time[srv_count] = now;
          push_pick(srv_count, 1'b1, ST_OK);
          srv_count++;
        end
      end
      OP_DISPATCH: begin
        n = redund_q;
        if (n > NPICK) n = NPICK;
        if (n > srv_count) n = srv_count;
        if (n == 0) begin
          push_pick(0, 1'b1, ST_NO_SRV);
        end else begin
          for (int i = 0; i < srv_count; i++) begin
            keys[i] = server_key(i, now);
            taken[i] = 1'b0;
          end
          for (int k = 0; k < n; k++) begin
            best = 0;
            have = 1'b0;
            for (int i = 0; i < srv_count; i++) begin
              if (!taken[i] && (!have || keys[i] > keys[best])) begin
                best = i;
                have = 1'b1;
              end
            end
            taken[best] = 1'b1;
            chosen[k] = best;
            push_pick(best, k + 1 == n, ST_OK);
          end
          for (int k = 0; k < n; k++) begin
            if (active_cnt[chosen[k]] != 16'hFFFF) active_cnt[chosen[k]]++;
            if (query_cnt[chosen[k]] != 32'hFFFFFFFF) query_cnt[chosen[k]]++;
          end
        end
      end
      OP_REPORT: begin
        if (sidx >= srv_count) begin
          push_pick(sidx, 1'b1, ST_BAD_IDX);
        end else begin
          if (resp_cnt[sidx] == 0) lat_avg[sidx] = {meas, 16'd0};
          else lat_avg[sidx] = smooth(lat_avg[sidx], {meas, 16'd0});
          if (resp_cnt[sidx] != 32'hFFFFFFFF) resp_cnt[sidx]++;
          succ_avg[sidx] = 17'(smooth(32'(succ_avg[sidx]), ok ? 32'h10000 : 32'd0));
          if (ok) last_ok_time[sidx] = now;
          if (active_cnt[sidx] != 0) active_cnt[sidx]--;
          push_pick(sidx, 1'b1, ST_OK);
        end
      end
      default: ;
    endcase
  endfunction

  task automatic send_word(input op_e op, input logic [3:0] sidx, input logic [15:0] meas,
                           input bit ok, input logic [31:0] now);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      s_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data <= {1'b0, now, ok, meas, sidx, op};
    do @(posedge clk_i); while (!s_ready);
    predict_word(op, sidx, meas, ok, now);
  endtask

  task automatic end_burst();
    s_valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain();
    while (pending_picks.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] reg_idx, input logic [31:0] value);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {reg_idx[0], 2'b00};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (reg_idx == REG_ALPHA) alpha_q = value[16:0];
    else redund_q = value[2:0];
  endtask

  task automatic set_config(input logic [16:0] alpha, input logic [2:0] redund);
    end_burst();
    drain();
    write_reg(REG_ALPHA, 32'(alpha));
    write_reg(REG_REDUNDANCY, 32'(redund));
  endtask

  task automatic random_word();
    int pick;
    op_e op;
    logic [31:0] now;
    logic [15:0] meas;
    pick = $urandom_range(0, 99);
    if (pick < 50) op = OP_REPORT;
    else if (pick < 80) op = OP_DISPATCH;
    else if (pick < 94) op = OP_ADD;
    else op = OP_NONE;
    clock_now += $urandom_range(0, 40);
    now = ($urandom_range(0, 19) == 0) ? $urandom() : clock_now;
    meas = ($urandom_range(0, 4) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 2000));
    send_word(op, 4'($urandom_range(0, 15)), meas, $urandom_range(0, 3) != 0, now);
  endtask

  always @(posedge clk_i) begin
    pick_t e;
    if (rst_ni) begin
      if (m_valid && m_ready) begin
        if (pending_picks.size() == 0) begin
          report_mismatch($sformatf("unexpected word idx=%0d", m_data[3:0]));
        end else begin
          e = pending_picks.pop_front();
          if (m_data[3:0] !== e.idx || m_last !== e.last || m_data[5:4] !== e.status ||
              m_data[7:6] !== 2'b00)
            report_mismatch($sformatf("got idx=%0d last=%0b st=%0d, want idx=%0d last=%0b st=%0d",
                                      m_data[3:0], m_last, m_data[5:4], e.idx, e.last,
                                      e.status));
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        m_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(0, 14);
        m_ready <= 1'b0;
      end else begin
        m_ready <= 1'b1;
      end
    end
  end

  task automatic test_empty_table();
    send_word(OP_DISPATCH, 4'd0, 16'd0, 1'b0, 32'd0);
    send_word(OP_REPORT, 4'd0, 16'd5, 1'b1, 32'd1);
    send_word(OP_REPORT, 4'd15, 16'hFFFF, 1'b0, 32'hFFFFFFFF);
    send_word(OP_NONE, 4'd7, 16'h1234, 1'b1, 32'd2);
  endtask

  task automatic test_few_servers();
    send_word(OP_ADD, 4'd0, 16'd0, 1'b0, 32'hFFFFFFF0);
    send_word(OP_ADD, 4'd0, 16'd0, 1'b0, 32'd100);
    send_word(OP_DISPATCH, 4'd0, 16'd0, 1'b0, 32'd110);
    send_word(OP_REPORT, 4'd0, 16'hFFFF, 1'b1, 32'd120);
    send_word(OP_REPORT, 4'd1, 16'd0, 1'b0, 32'd130);
    send_word(OP_REPORT, 4'd0, 16'd0, 1'b0, 32'd140);
    send_word(OP_REPORT, 4'd2, 16'd10, 1'b1, 32'd150);
    send_word(OP_DISPATCH, 4'd0, 16'd0, 1'b0, 32'd400);
  endtask

  task automatic test_full_table();
    for (int i = 2; i < NSRV; i++)
      send_word(OP_ADD, 4'd0, 16'd0, 1'b0, clock_now + 32'(i));
    send_word(OP_ADD, 4'd0, 16'd0, 1'b0, clock_now);
    send_word(OP_DISPATCH, 4'd0, 16'd0, 1'b0, clock_now);
  endtask

  task automatic test_register_extremes();
    set_config(17'd0, 3'd0);
    send_word(OP_DISPATCH, 4'd0, 16'd0, 1'b0, clock_now);
    send_word(OP_REPORT, 4'd3, 16'd900, 1'b0, clock_now);
    send_word(OP_REPORT, 4'd3, 16'd50, 1'b1, clock_now);
    set_config(17'h10000, 3'd7);
    send_word(OP_DISPATCH, 4'd0, 16'd0, 1'b0, clock_now);
    send_word(OP_REPORT, 4'd4, 16'd300, 1'b1, clock_now);
    send_word(OP_REPORT, 4'd4, 16'd70, 1'b0, clock_now);
    set_config(17'h1FFFF, 3'd1);
    send_word(OP_DISPATCH, 4'd0, 16'd0, 1'b0, clock_now);
    send_word(OP_REPORT, 4'd5, 16'd20, 1'b1, clock_now);
    send_word(OP_REPORT, 4'd5, 16'd40, 1'b1, clock_now);
  endtask

  task automatic test_random_traffic(input int count, input logic [16:0] alpha,
                                     input logic [2:0] redund);
    set_config(alpha, redund);
    for (int i = 0; i < count; i++) random_word();
  endtask

  task automatic test_backpressure();
    set_config(17'($urandom_range(0, 65536)), 3'd5);
    hold_left = 3000;
    for (int i = 0; i < 12; i++) random_word();
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_table();
    test_few_servers();
    test_full_table();
    test_register_extremes();
    test_random_traffic(110, 17'd6554, 3'd3);
    test_backpressure();
    test_random_traffic(110, 17'($urandom_range(0, 65536)), 3'($urandom_range(1, 5)));
    test_random_traffic(100, 17'($urandom_range(0, 65536)), 3'd2);
    idle_on = 1'b0;
    test_random_traffic(100, 17'($urandom_range(0, 65536)), 3'($urandom_range(1, 5)));
    end_burst();
    drain();
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
